/* rtl/round_robin_time_slice_scheduler_assert.svh */
// Assertion macros shared by the scheduler's checker.
// Each macro expands to one labeled concurrent assertion clocked on its clk argument.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scheduler check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scheduler check failed one cycle later");

`endif

/* rtl/rrts_pkg.sv */
// Shared types and constants of the round robin time slice scheduler.
// Used by the table memory, the controller, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

    localparam int DEFAULT_MAX_PROCS = 16;

    // Packed stream widths, padded to whole bytes.
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 144;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] KIND_SLICE    = 3'd0;
    localparam logic [2:0] KIND_IDLE     = 3'd1;
    localparam logic [2:0] KIND_DONE     = 3'd2;
    localparam logic [2:0] KIND_LOAD_OK  = 3'd3;
    localparam logic [2:0] KIND_LOAD_REJ = 3'd4;

    typedef struct packed {
        logic [7:0]  pid;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
    } rrts_entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  slice_pid;
        logic [31:0] slice_start;
        logic [31:0] slice_end;
        logic        finished;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic        time_saturated;
    } rrts_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_DONE,
        ST_EMIT
    } rrts_state_t;

endpackage

`default_nettype wire

/* rtl/rrts_table_mem.sv */
// Process table: one synchronous memory of process records.
// One write port and one read port with a registered read; depends on rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrts_table_mem #(
    parameter int DEPTH = rrts_pkg::DEFAULT_MAX_PROCS
) (
    input  wire                          aclk,
    input  wire                          we,
    input  wire [$clog2(DEPTH)-1:0]      waddr,
    input  rrts_pkg::rrts_entry_t        wdata,
    input  wire                          re,
    input  wire [$clog2(DEPTH)-1:0]      raddr,
    output rrts_pkg::rrts_entry_t        rdata
);
    import rrts_pkg::*;

    rrts_entry_t entry_mem [DEPTH];
    rrts_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            entry_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= entry_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/rrts_ctrl.sv */
// Scheduler controller: command decode, table scan, slice arithmetic and counters.
// Drives the process table memory; depends on rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrts_ctrl #(
    parameter int MAX_PROCS = rrts_pkg::DEFAULT_MAX_PROCS
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire [1:0]                        in_op,
    input  wire [7:0]                        in_pid,
    input  wire [15:0]                       in_arrival,
    input  wire [15:0]                       in_burst,
    input  wire [15:0]                       quantum,
    output logic                             res_valid,
    input  wire                              res_ready,
    output rrts_pkg::rrts_result_t           res,
    output logic                             mem_we,
    output logic [$clog2(MAX_PROCS)-1:0]     mem_waddr,
    output rrts_pkg::rrts_entry_t            mem_wdata,
    output logic                             mem_re,
    output logic [$clog2(MAX_PROCS)-1:0]     mem_raddr,
    input  rrts_pkg::rrts_entry_t            mem_rdata
);
    import rrts_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    rrts_state_t  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] completed_reg, completed_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic             pass_reg, pass_next;
    logic [31:0]      time_reg, time_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    rrts_entry_t      hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [16:0]      ab_reg, ab_next;
    rrts_result_t     res_reg, res_next;

    logic             step_empty;
    logic             entry_rdy;
    logic             pass_end;
    logic [31:0]      time_inc;
    logic [15:0]      q_eff;
    logic [15:0]      run;
    logic [15:0]      new_rem;
    logic [32:0]      end_sum;
    logic [31:0]      end_sat;
    logic [CNT_W-1:0] hit_succ;

    assign step_empty = (count_reg == '0) || (completed_reg >= count_reg);
    // The read data belongs to the entry issued in the previous cycle.
    assign entry_rdy  = chk_valid_reg && (mem_rdata.remaining != 16'd0) &&
                        ({16'd0, mem_rdata.arrival} <= time_reg);
    assign pass_end   = (issue_reg == count_reg) && !entry_rdy;
    assign time_inc   = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + 32'd1;

    assign q_eff      = (quantum == 16'd0) ? 16'd1 : quantum;
    assign run        = (hit_reg.remaining < q_eff) ? hit_reg.remaining : q_eff;
    assign new_rem    = hit_reg.remaining - run;
    assign end_sum    = {1'b0, time_reg} + {17'd0, run};
    assign end_sat    = end_sum[32] ? TIME_MAX : end_sum[31:0];
    assign hit_succ   = CNT_W'(hit_idx_reg) + CNT_W'(1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    case (in_op)
                        OP_LOAD:  state_next = ST_EMIT;
                        OP_STEP:  state_next = step_empty ? ST_EMIT : ST_SCAN;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (entry_rdy) begin
                    state_next = ST_EXEC;
                end else if (pass_end && !pass_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EXEC: state_next = ST_DONE;
            ST_DONE: state_next = ST_EMIT;
            ST_EMIT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        count_next     = count_reg;
        completed_next = completed_reg;
        scan_next      = scan_reg;
        pass_next      = pass_reg;
        time_next      = time_reg;
        issue_next     = issue_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        ab_next        = ab_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    case (in_op)
                        OP_LOAD: begin
                            res_next = '0;
                            res_next.time_saturated = (time_reg == TIME_MAX);
                            if (in_burst == 16'd0 || count_reg >= CNT_W'(MAX_PROCS)) begin
                                res_next.kind = KIND_LOAD_REJ;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = count_reg[IDX_W-1:0];
                                mem_wdata = '{pid: in_pid, arrival: in_arrival,
                                              burst: in_burst, remaining: in_burst};
                                count_next = count_reg + CNT_W'(1);
                                res_next.kind = KIND_LOAD_OK;
                            end
                        end
                        OP_STEP: begin
                            res_next = '0;
                            res_next.time_saturated = (time_reg == TIME_MAX);
                            if (step_empty) begin
                                res_next.kind = KIND_DONE;
                            end else begin
                                chk_valid_next = 1'b0;
                                if (CNT_W'(scan_reg) >= count_reg) begin
                                    issue_next = '0;
                                    scan_next  = '0;
                                    pass_next  = 1'b0;
                                end else begin
                                    issue_next = CNT_W'(scan_reg);
                                end
                            end
                        end
                        OP_CLEAR: begin
                            count_next     = '0;
                            completed_next = '0;
                            scan_next      = '0;
                            pass_next      = 1'b0;
                            time_next      = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (entry_rdy) begin
                    hit_next     = mem_rdata;
                    hit_idx_next = chk_idx_reg;
                end else if (issue_reg == count_reg) begin
                    chk_valid_next = 1'b0;
                    if (pass_reg) begin
                        // The pass ran out after a dispatch: rescan from the top.
                        pass_next  = 1'b0;
                        issue_next = '0;
                    end else begin
                        time_next            = time_inc;
                        scan_next            = '0;
                        pass_next            = 1'b0;
                        res_next.kind        = KIND_IDLE;
                        res_next.slice_start = time_reg;
                        res_next.slice_end   = time_inc;
                        res_next.time_saturated = (time_inc == TIME_MAX);
                    end
                end else begin
                    mem_re         = 1'b1;
                    mem_raddr      = issue_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_reg[IDX_W-1:0];
                    issue_next     = issue_reg + CNT_W'(1);
                end
            end
            ST_EXEC: begin
                mem_we    = 1'b1;
                mem_waddr = hit_idx_reg;
                mem_wdata = '{pid: hit_reg.pid, arrival: hit_reg.arrival,
                              burst: hit_reg.burst, remaining: new_rem};
                time_next            = end_sat;
                res_next.kind        = KIND_SLICE;
                res_next.slice_pid   = hit_reg.pid;
                res_next.slice_start = time_reg;
                res_next.slice_end   = end_sat;
                res_next.finished    = (new_rem == 16'd0);
                if (new_rem == 16'd0) begin
                    completed_next = completed_reg + CNT_W'(1);
                end
                ab_next = {1'b0, hit_reg.arrival} + {1'b0, hit_reg.burst};
                if (hit_succ >= count_reg) begin
                    scan_next = '0;
                    pass_next = 1'b0;
                end else begin
                    scan_next = hit_succ[IDX_W-1:0];
                    pass_next = 1'b1;
                end
            end
            ST_DONE: begin
                res_next.time_saturated = (time_reg == TIME_MAX);
                if (res_reg.finished) begin
                    res_next.turnaround = res_reg.slice_end - {16'd0, hit_reg.arrival};
                    // Turnaround minus burst equals end minus (arrival plus burst).
                    res_next.waiting = (res_reg.slice_end >= {15'd0, ab_reg}) ?
                                       res_reg.slice_end - {15'd0, ab_reg} : 32'd0;
                end
            end
            ST_EMIT: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            completed_reg <= '0;
            scan_reg      <= '0;
            pass_reg      <= 1'b0;
            time_reg      <= '0;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            completed_reg <= completed_next;
            scan_reg      <= scan_next;
            pass_reg      <= pass_next;
            time_reg      <= time_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_idx_reg <= chk_idx_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        ab_reg      <= ab_next;
        res_reg     <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* rtl/round_robin_time_slice_scheduler.sv */
// Top level of the round robin time slice scheduler: stream ports, quantum
// register and result register. Depends on rrts_pkg, rrts_ctrl, rrts_table_mem.
//
//   channel   direction  handshake              payload
//   s_*       in         s_tvalid / s_tready    tuser: operation; tdata: record
//   m_*       out        m_tvalid / m_tready    tuser: kind; tdata: slice report
//   cfg_*     in         cfg_valid / cfg_ready  cfg_data: time quantum
//
// A load is decoded in the idle state and its result handed over from the emit
// state; clear and unknown items give no result. A dispatch reads one table entry
// a cycle while scanning; a pass begun after a dispatch wraps to the top of the
// table when it runs out. An idle tick goes from the scan straight to the result.
// Reset is synchronous and active low; the quantum resets to 1.
// A stalled result holds in the output register; meanwhile one more result is made.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_time_slice_scheduler #(
    parameter int MAX_PROCS = rrts_pkg::DEFAULT_MAX_PROCS
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // [7:0] proc_id, [23:8] arrival, [39:24] burst
    input  wire [rrts_pkg::S_DATA_W-1:0]     s_tdata,
    // [1:0] operation
    input  wire [1:0]                        s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [7:0] slice_pid, [39:8] slice_start, [71:40] slice_end, [72] finished,
    // [104:73] turnaround, [136:105] waiting, [137] time_saturated, rest zero
    output logic [rrts_pkg::M_DATA_W-1:0]    m_tdata,
    // [2:0] kind
    output logic [2:0]                       m_tuser,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [15:0]                       cfg_data
);
    import rrts_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCS);

    logic [15:0]  quantum_reg;
    logic         m_valid_reg;
    rrts_result_t out_reg;

    logic         res_valid;
    logic         res_ready;
    rrts_result_t res;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    rrts_entry_t      mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    rrts_entry_t      mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= 16'd1;
        end else if (cfg_valid) begin
            quantum_reg <= cfg_data;
        end
    end

    rrts_ctrl #(
        .MAX_PROCS (MAX_PROCS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_pid     (s_tdata[7:0]),
        .in_arrival (s_tdata[23:8]),
        .in_burst   (s_tdata[39:24]),
        .quantum    (quantum_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    rrts_table_mem #(
        .DEPTH (MAX_PROCS)
    ) u_table_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The output register takes a new result when it is empty or being drained.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'd0, out_reg.time_saturated, out_reg.waiting, out_reg.turnaround,
                       out_reg.finished, out_reg.slice_end, out_reg.slice_start,
                       out_reg.slice_pid};

endmodule

`default_nettype wire

/* rtl/rrts_checker.sv */
// Port-level checker of the round robin time slice scheduler and its bind.
// Depends on rrts_pkg and round_robin_time_slice_scheduler_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_time_slice_scheduler_assert.svh"

module rrts_port_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [rrts_pkg::M_DATA_W-1:0]  m_tdata,
    input wire [2:0]                     m_tuser
);
    import rrts_pkg::*;

    logic [31:0] c_start;
    logic [31:0] c_end;
    logic        c_finished;
    logic        c_sat;

    assign c_start    = m_tdata[39:8];
    assign c_end      = m_tdata[71:40];
    assign c_finished = m_tdata[72];
    assign c_sat      = m_tdata[137];

    // A stalled result beat holds.
    `RRTS_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // An idle tick advances time by exactly one unless it is pinned at the maximum.
    `RRTS_ASSERT_SAME(a_idle_tick, aclk, aresetn, m_tvalid && (m_tuser == KIND_IDLE),
        (c_end == c_start + 32'd1) || ((c_start == TIME_MAX) && (c_end == TIME_MAX)))

    // A slice always runs for at least one time unit before saturation.
    `RRTS_ASSERT_SAME(a_slice_len, aclk, aresetn, m_tvalid && (m_tuser == KIND_SLICE),
        (c_end > c_start) || (c_start == TIME_MAX))

    // Only a slice can finish a process.
    `RRTS_ASSERT_SAME(a_finish_kind, aclk, aresetn, m_tvalid && c_finished,
        m_tuser == KIND_SLICE)

    // A slice or tick that ends at the maximum time leaves the clock saturated.
    `RRTS_ASSERT_SAME(a_sat_flag, aclk, aresetn,
        m_tvalid && ((m_tuser == KIND_SLICE) || (m_tuser == KIND_IDLE)) &&
        (c_end == TIME_MAX), c_sat)

endmodule

bind round_robin_time_slice_scheduler rrts_port_checker u_rrts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
